// ----- src/lrpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpf_pkg: shared types for the log record page framer
// Word layouts for both channels, the internal command word and its codes.
// ----------------------------------------------------------------------------
package lrpf_pkg;

	localparam int HEADER_BYTES = 6;
	localparam int ADDR_W       = 12;
	localparam int QUEUE_DEPTH  = 4;
	localparam int STEP_W       = 3;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_PAD   = 2'd1,
		KIND_DROP  = 2'd2
	} write_kind_t;

	typedef enum logic [1:0] {
		CMD_HEADER = 2'd0,
		CMD_BYTE   = 2'd1,
		CMD_DROP   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic        func;
		logic [7:0]  record_type;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [15:0] millis;
		logic [7:0]  payload_count;
		logic [7:0]  payload_byte;
	} in_item_t;

	typedef struct packed {
		write_kind_t         write_kind;
		logic [ADDR_W-1:0]   write_address;
		logic [7:0]          write_data;
		logic                run_last;
	} out_item_t;

	// One classified input word: a header to expand or a single result.
	typedef struct packed {
		cmd_kind_t           kind;
		logic                pad;
		logic [ADDR_W-1:0]   pad_addr;
		logic [ADDR_W-1:0]   base;
		logic [7:0]          data;
		logic [4:0]          hours;
		logic [5:0]          minutes;
		logic [5:0]          seconds;
		logic [15:0]         millis;
	} cmd_t;

endpackage

// ----- src/lrpf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpf_front: input classifier
// Tracks fill pointer and expected payload, turns each word into a command.
// ----------------------------------------------------------------------------
module lrpf_front import lrpf_pkg::*; #(
	parameter int PAGE_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  in_item_t   item,
	input  logic       full,
	output logic       item_stall,
	output logic       push,
	output cmd_t       cmd
);

	localparam int FP_W = $clog2(PAGE_BYTES + 1);

	logic [FP_W-1:0]        fill_q;
	logic [7:0]             left_q;
	logic [FP_W-1:0]        fill_next;
	logic [7:0]             left_next;
	logic [FP_W:0]          need;
	logic                   pad;
	logic [FP_W-1:0]        base;
	logic                   accept;

	assign item_stall = full;
	assign accept     = item_valid && !full;
	assign push       = accept;

	assign need      = {1'b0, fill_q} + (FP_W+1)'(HEADER_BYTES)
	                   + {{(FP_W-7){1'b0}}, item.payload_count};
	assign pad       = need > (FP_W+1)'(PAGE_BYTES);
	assign base      = pad ? '0 : fill_q;

	always_comb begin
		cmd         = '0;
		fill_next   = fill_q;
		left_next   = left_q;
		cmd.hours   = item.hours;
		cmd.minutes = item.minutes;
		cmd.seconds = item.seconds;
		cmd.millis  = item.millis;
		if (!item.func) begin
			cmd.kind     = CMD_HEADER;
			cmd.pad      = pad;
			cmd.pad_addr = ADDR_W'(fill_q);
			cmd.base     = ADDR_W'(base);
			cmd.data     = item.record_type;
			fill_next    = base + FP_W'(HEADER_BYTES);
			left_next    = item.payload_count;
		end else if (left_q != 8'd0 && fill_q < FP_W'(PAGE_BYTES)) begin
			cmd.kind  = CMD_BYTE;
			cmd.base  = ADDR_W'(fill_q);
			cmd.data  = item.payload_byte;
			fill_next = fill_q + 1'b1;
			left_next = left_q - 8'd1;
		end else begin
			cmd.kind = CMD_DROP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			left_q <= '0;
		end else if (accept) begin
			fill_q <= fill_next;
			left_q <= left_next;
		end
	end

endmodule

// ----- src/lrpf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpf_queue: command queue
// Small circular buffer between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module lrpf_queue import lrpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       wr_cmd,
	input  logic       pop,
	output logic       full,
	output logic       head_valid,
	output cmd_t       head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full       = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/lrpf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpf_back: result sequencer
// Expands the head command into results, one per cycle while the result side does not stall, into the output word.
// ----------------------------------------------------------------------------
module lrpf_back import lrpf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head,
	output logic      pop,
	input  logic      result_stall,
	output logic      result_valid,
	output out_item_t result
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] idx;
	logic [STEP_W-1:0] byte_idx;
	logic              load;
	logic              last;
	out_item_t         res;
	out_item_t         result_q;
	logic              result_valid_q;

	assign load         = head_valid && (!result_valid_q || !result_stall);
	assign pop          = load && last;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	// Header sequence index: 0 is the pad, 1..6 the header bytes.
	assign idx      = step_q + {{(STEP_W-1){1'b0}}, ~head.pad};
	assign byte_idx = idx - 1'b1;

	always_comb begin
		res      = '0;
		last     = 1'b1;
		unique case (head.kind)
			CMD_HEADER: begin
				last = idx == STEP_W'(HEADER_BYTES);
				res.run_last = last;
				if (idx == '0) begin
					res.write_kind    = KIND_PAD;
					res.write_address = head.pad_addr;
				end else begin
					res.write_kind    = KIND_WRITE;
					res.write_address = head.base + {{(ADDR_W-STEP_W){1'b0}}, byte_idx};
					case (byte_idx)
						3'd0:    res.write_data = head.data;
						3'd1:    res.write_data = {3'b0, head.hours};
						3'd2:    res.write_data = {2'b0, head.minutes};
						3'd3:    res.write_data = {2'b0, head.seconds};
						3'd4:    res.write_data = head.millis[7:0];
						default: res.write_data = head.millis[15:8];
					endcase
				end
			end
			CMD_BYTE: begin
				res.write_kind    = KIND_WRITE;
				res.write_address = head.base;
				res.write_data    = head.data;
				res.run_last      = 1'b1;
			end
			default: begin
				res.write_kind = KIND_DROP;
				res.run_last   = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (!result_valid_q || !result_stall) begin
				result_valid_q <= head_valid;
			end
			if (load) begin
				step_q <= last ? '0 : step_q + 1'b1;
			end
		end
	end

endmodule

// ----- src/log_record_page_framer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_record_page_framer_top: log record page framer
// Packs timestamped log records into byte writes for one flash page buffer.
// ----------------------------------------------------------------------------
// A header word (func 0) yields six byte writes (type, hours, minutes,
// seconds, millis low, millis high), preceded by one pad-and-flush command
// when the header plus its announced payload would not fit in what is left
// of the PAGE_BYTES page; the fill pointer then restarts at 0. Each payload
// word (func 1) yields one byte write, or a drop result if the header did
// not announce it. run_last marks the last result of each input word.
// Rate: the result sequencer emits one result per cycle while the result side
// does not stall, so a payload word yields one result and a header six or
// seven; with a free result side, payload words stream at one per cycle. A
// four-entry command queue sits between the classifier and the sequencer, so
// input words keep flowing while a header is being expanded or the result
// side stalls; item_stall rises only when that queue is full. A word passes
// the queue, then the result register. No clearing pass after reset.
// ----------------------------------------------------------------------------
module log_record_page_framer_top import lrpf_pkg::*; #(
	parameter int PAGE_BYTES = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	logic       push;
	cmd_t       cmd;
	cmd_t       head;
	logic       full;
	logic       head_valid;
	logic       pop;

	// Classify the word and advance the fill pointer at accept.
	lrpf_front #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item      (item),
		.full      (full),
		.item_stall(item_stall),
		.push      (push),
		.cmd       (cmd)
	);

	// Hold commands while the sequencer works or the output stalls.
	lrpf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (cmd),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head      (head)
	);

	// Expand the head command into result words.
	lrpf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

// ----- verif/log_record_page_framer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_record_page_framer_top_test: self-checking bench for the page framer
// Drives header and payload words through the valid/stall channel, predicts
// every byte write, pad-and-flush and drop result, and checks each result
// word in order. Covers field extremes, dropped and abandoned payload,
// back pressure that fills the command queue, and a random run of mostly
// well-formed records.
// ----------------------------------------------------------------------------
module log_record_page_framer_top_test;
	import lrpf_pkg::*;

	localparam int PAGE_SIZE = 4096;
	localparam logic FUNC_HEADER = 1'b0;
	localparam logic FUNC_PAYLOAD = 1'b1;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	in_item_t item;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;

	// Prediction state: next free page offset and payload bytes still owed.
	logic [12:0] pred_fill = '0;
	logic [7:0] pred_left = '0;
	out_item_t expected_writes[$];

	int mismatch_count = 0;
	int words_sent = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	// Receiver hold-off: cycles still to stall, and a request for a long hold.
	int stall_left = 0;
	int hold_request = 0;

	log_record_page_framer_top #(.PAGE_BYTES(PAGE_SIZE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Bound the run well above the slowest legal pace of all phases.
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic out_item_t make_write(input write_kind_t kind,
			input logic [ADDR_W-1:0] addr, input logic [7:0] data);
		out_item_t r;
		r.write_kind = kind;
		r.write_address = addr;
		r.write_data = data;
		r.run_last = 1'b0;
		return r;
	endfunction

	// Expand one accepted word into its page writes and queue them.
	function automatic void predict_page_writes(input in_item_t w);
		out_item_t batch[$];
		logic [7:0] hdr[HEADER_BYTES];
		if (w.func == FUNC_HEADER) begin
			// Pad and flush when the whole record would overrun the page.
			if (int'(pred_fill) + HEADER_BYTES + int'(w.payload_count) > PAGE_SIZE) begin
				batch.push_back(make_write(KIND_PAD, pred_fill[ADDR_W-1:0], 8'h00));
				pred_fill = '0;
			end
			hdr[0] = w.record_type;
			hdr[1] = {3'b000, w.hours};
			hdr[2] = {2'b00, w.minutes};
			hdr[3] = {2'b00, w.seconds};
			hdr[4] = w.millis[7:0];
			hdr[5] = w.millis[15:8];
			for (int i = 0; i < HEADER_BYTES; i++) begin
				batch.push_back(make_write(KIND_WRITE, pred_fill[ADDR_W-1:0], hdr[i]));
				pred_fill = pred_fill + 13'd1;
			end
			// A new header abandons whatever payload was still owed.
			pred_left = w.payload_count;
		end else if (pred_left != 0 && int'(pred_fill) < PAGE_SIZE) begin
			batch.push_back(make_write(KIND_WRITE, pred_fill[ADDR_W-1:0], w.payload_byte));
			pred_fill = pred_fill + 13'd1;
			pred_left = pred_left - 8'd1;
		end else begin
			batch.push_back(make_write(KIND_DROP, '0, 8'h00));
		end
		batch[batch.size() - 1].run_last = 1'b1;
		foreach (batch[i])
			expected_writes.push_back(batch[i]);
	endfunction

	// ------------------------------------------------------------------
	// Word builders: unused fields carry random in-range junk.
	// ------------------------------------------------------------------
	function automatic in_item_t header_word(input int count);
		in_item_t w;
		w.func = FUNC_HEADER;
		w.record_type = 8'($urandom_range(0, 255));
		w.hours = 5'($urandom_range(0, 23));
		w.minutes = 6'($urandom_range(0, 59));
		w.seconds = 6'($urandom_range(0, 59));
		w.millis = 16'($urandom_range(0, 65535));
		w.payload_count = 8'(count);
		w.payload_byte = 8'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic in_item_t payload_word(input logic [7:0] data);
		in_item_t w;
		w = header_word($urandom_range(0, 255));
		w.func = FUNC_PAYLOAD;
		w.payload_byte = data;
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Sender: entered at a falling edge, returns at a falling edge with
	// valid still high so back-to-back words never drop valid.
	// ------------------------------------------------------------------
	task automatic send_word(input in_item_t w);
		int gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item = w;
		item_valid = 1'b1;
		// Hold the word until a rising edge sees stall low.
		do
			@(posedge clk);
		while (item_stall);
		predict_page_writes(w);
		words_sent++;
		@(negedge clk);
	endtask

	// Send a header announcing count bytes, then sent_bytes payload words.
	task automatic send_record(input int count, input int sent_bytes);
		send_word(header_word(count));
		repeat (sent_bytes)
			send_word(payload_word(8'($urandom_range(0, 255))));
	endtask

	// ------------------------------------------------------------------
	// Receiver: stall is driven at the falling edge from a cycle count.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_request != 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			result_stall = 1'b1;
			stall_left--;
		end else begin
			result_stall = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Checker: compare every accepted result with the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_writes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: kind %0d addr %0d data %0d last %0d",
						result.write_kind, result.write_address, result.write_data,
						result.run_last);
			end else begin
				want = expected_writes.pop_front();
				if (result.write_kind !== want.write_kind
						|| result.write_address !== want.write_address
						|| result.write_data !== want.write_data
						|| result.run_last !== want.run_last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: expected kind %0d addr %0d data %0d last %0d,",
							want.write_kind, want.write_address, want.write_data,
							want.run_last,
							" got kind %0d addr %0d data %0d last %0d",
							result.write_kind, result.write_address,
							result.write_data, result.run_last);
				end
			end
			// Draw the stall that follows this result word.
			stall_left = rx_idle ? $urandom_range(0, 6) : 0;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Payload before any header is dropped.
	task automatic test_lone_payload;
		send_word(payload_word(8'hA5));
	endtask

	// Header fields at both ends of their ranges, payload bytes 0x00 and 0xFF,
	// then one byte past the announced count and after a count of zero.
	task automatic test_field_extremes;
		in_item_t w;
		w.func = FUNC_HEADER;
		w.record_type = 8'hFF;
		w.hours = 5'd23;
		w.minutes = 6'd59;
		w.seconds = 6'd59;
		w.millis = 16'hFFFF;
		w.payload_count = 8'd2;
		w.payload_byte = 8'h00;
		send_word(w);
		send_word(payload_word(8'hFF));
		send_word(payload_word(8'h00));
		send_word(payload_word(8'h5A));
		w = '0;
		w.func = FUNC_HEADER;
		w.payload_byte = 8'hFF;
		send_word(w);
		send_word(payload_word(8'h3C));
		w.payload_count = 8'd255;
		send_word(w);
		send_word(payload_word(8'hFF));
	endtask

	// A new header arrives before the announced payload is complete.
	task automatic test_abandoned_payload;
		send_record(5, 2);
		send_record(1, 1);
		send_word(payload_word(8'h81));
	endtask

	// Hold the result side for a long stretch while words keep coming, so
	// the command queue fills and the input side stalls.
	task automatic test_back_pressure;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_request = HOLD_CYCLES;
		send_record(6, 6);
		send_record(6, 6);
		send_record(6, 6);
		rx_idle = 1'b1;
		send_record(2, 2);
	endtask

	// Mostly well-formed records with random content; the rest are stray
	// payload bytes, abandoned records and records with extra bytes.
	task automatic test_random_records(input int word_goal);
		int start;
		int count;
		int pick;
		start = words_sent;
		while (words_sent - start < word_goal) begin
			// Switch idling in stretches, including spells with none at all.
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
				: $urandom_range(0, 12);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				send_word(payload_word(8'($urandom_range(0, 255))));
			else if (pick == 1)
				send_record(count + 1, $urandom_range(0, count));
			else if (pick == 2)
				send_record(count, count + $urandom_range(1, 2));
			else
				send_record(count, count);
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_lone_payload();
		test_field_extremes();
		test_abandoned_payload();
		test_back_pressure();
		test_random_records(110);

		// Drop valid, drain every prediction, then allow the pipeline latency.
		item_valid = 1'b0;
		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_writes.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
